/* rtl/core/assert_macros.svh */
// Assertion macros included by the core top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* rtl/core/uodc_pkg.sv */
// Types and constants for the drive controller core
package uodc_pkg;
    localparam int unsigned DutyMax = 99;

    typedef enum logic [2:0] {
        FUNC_ECHO  = 3'd0,
        FUNC_TICK  = 3'd1,
        FUNC_CMD   = 3'd2,
        FUNC_SPEED = 3'd3,
        FUNC_MS    = 3'd4
    } func_code_t;

    typedef enum logic [2:0] {
        CFG_DIVISOR = 3'd0,
        CFG_NEAR    = 3'd1,
        CFG_FAR     = 3'd2,
        CFG_SETTLE  = 3'd3,
        CFG_QUARTER = 3'd4,
        CFG_HALF    = 3'd5,
        CFG_FLOOR   = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [2:0]  func;
        logic        echo_level;
        logic [15:0] capture_time;
        logic [7:0]  command_byte;
        logic [11:0] speed_sample;
    } in_item_t;

    typedef struct packed {
        logic [6:0] duty_a;
        logic [6:0] duty_b;
        logic       dir_a;
        logic       dir_b;
        logic       buzzer_on;
        logic [9:0] range_cm;
        logic [1:0] zone;
        logic       cmd_error;
    } out_item_t;

    // Control/status between the sequencer and the serial divider
    typedef struct packed {
        logic        start;
        logic [17:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [17:0] quotient;
    } div_rsp_t;
endpackage

/* rtl/core/uodc_serial_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle
module uodc_serial_div (
    input  logic               clk,
    input  logic               rst_n,
    input  uodc_pkg::div_req_t req,
    output uodc_pkg::div_rsp_t rsp
);
    import uodc_pkg::*;

    logic [17:0] quo_reg, quo_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[17]};
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 5'd18;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = 16'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[16:0], 1'b1};
            end
            else
            begin
                rem_next = trial[15:0];
                quo_next = {quo_reg[16:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule

/* rtl/core/ultrasonic_obstacle_drive_controller_core.sv */
// Ultrasonic obstacle drive controller: top level and event sequencer
// Usage:
//  - in_valid/in_ready carry one event (in_item_t); out_valid/out_ready
//    carry exactly one result (out_item_t) per event, in order.
//  - cfg_we/cfg_index/cfg_data write one of the seven setup registers;
//    write only while no event is in flight.
//  - One event at a time. Echo falls and speed samples run one serial
//    divide; automatic-mode caution ticks with a nonempty span run two
//    (one per wheel), each after a product state and a start state.
//    The next event is taken at the earliest in the cycle the result
//    transfers, so events never overlap.
//  - The result waits in an output register; the next event is taken
//    once that register has been handed over or is being taken.
//  - Reset loads register defaults (divisor 90, limits 10/20, waits
//    500/480/970 ms, floor 35), mode stop, top duty 50, drive zero, out_valid low.
//  - A stalled receiver holds the result and blocks new events.
module ultrasonic_obstacle_drive_controller_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  uodc_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output uodc_pkg::out_item_t  out_data,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data
);
    import uodc_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_ECHO_DIV, S_SPEED_DIV, S_BRK_A, S_BRK_B,
        S_MUL, S_BRK_WAIT, S_FINISH
    } state_t;

    state_t       state_reg;
    state_t       decode_next;
    in_item_t     item_reg;
    out_item_t    out_reg;
    logic         out_valid_reg;

    logic [9:0]  divisor_cfg_reg, near_cfg_reg, far_cfg_reg;
    logic [15:0] settle_cfg_reg, quarter_cfg_reg, half_cfg_reg;
    logic [6:0]  floor_cfg_reg;

    logic [15:0] echo_start_reg;
    logic [9:0]  range_reg;
    logic [1:0]  zone_reg;
    logic [2:0]  turn_phase_reg, last_turn_reg, drive_mode_reg;
    logic [6:0]  top_duty_reg;
    logic        echo_en_reg;
    logic [15:0] phase_timer_reg;
    logic [1:0]  timer_kind_reg;
    logic [6:0]  duty_a_reg, duty_b_reg;
    logic        dir_a_reg, dir_b_reg, buzzer_reg;
    logic        err_reg;

    // brake computation
    logic        brk_sel_reg;   // 0: wheel a, 1: wheel b
    logic        brk_neg_reg;
    logic [17:0] prod_reg;
    logic [6:0]  brk_a_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    uodc_serial_div u_div (
        .clk (clk),
        .rst_n (rst_n),
        .req (div_req),
        .rsp (div_rsp)
    );

    logic [6:0]  peak_a;
    logic [6:0]  peak_sel;
    logic signed [8:0]  pk_minus_fl;
    logic signed [11:0] d_minus_n;
    logic signed [11:0] span;
    logic signed [20:0] prod_s;
    logic [15:0] echo_width;
    logic [9:0]  dist_cm;
    logic signed [18:0] brk_q;
    logic signed [19:0] brk_sum;
    logic [6:0]  brk_clamped;
    logic [6:0]  floor_clamped;
    logic        cmd_ok;
    logic        turn_ovr;
    logic        ph_ok;

    assign peak_a      = top_duty_reg - 7'((15'(top_duty_reg) * 15'd205) >> 11);
    assign peak_sel    = brk_sel_reg ? top_duty_reg : peak_a;
    assign pk_minus_fl = $signed({2'b0, peak_sel}) - $signed({2'b0, floor_cfg_reg});
    assign d_minus_n   = $signed({2'b0, range_reg}) - $signed({2'b0, near_cfg_reg});
    assign span        = $signed({2'b0, far_cfg_reg}) - $signed({2'b0, near_cfg_reg});
    assign prod_s      = 21'(pk_minus_fl) * 21'(d_minus_n);
    assign echo_width  = item_reg.capture_time - echo_start_reg;
    assign dist_cm     = (div_rsp.quotient > 18'd1023) ? 10'd1023
                                                       : div_rsp.quotient[9:0];
    assign brk_q       = brk_neg_reg ? -$signed({1'b0, div_rsp.quotient})
                                     : $signed({1'b0, div_rsp.quotient});
    assign brk_sum     = 20'(brk_q) + $signed({13'b0, floor_cfg_reg});
    assign brk_clamped = brk_sum < 0 ? 7'd0
                       : (brk_sum > 20'sd99 ? 7'(DutyMax) : brk_sum[6:0]);
    assign floor_clamped = (floor_cfg_reg > 7'(DutyMax)) ? 7'(DutyMax) : floor_cfg_reg;
    assign cmd_ok      = item_reg.command_byte inside {[8'h31:8'h36]};

    assign ph_ok    = turn_phase_reg == 3'd2 || turn_phase_reg == 3'd3 ||
                      turn_phase_reg == 3'd4;
    assign turn_ovr = item_reg.func == FUNC_TICK && timer_kind_reg == 2'd2 && ph_ok;

    always_comb
    begin
        decode_next = S_FINISH;
        case (item_reg.func)
            FUNC_ECHO:
                if (echo_en_reg && !item_reg.echo_level)
                    decode_next = S_ECHO_DIV;
            FUNC_SPEED: decode_next = S_SPEED_DIV;
            FUNC_TICK:
                if (drive_mode_reg == 3'd6 && zone_reg == 2'd1 && span > 0)
                    decode_next = S_BRK_A;
            default: ;
        endcase
    end

    always_comb
    begin
        div_req = '0;
        case (state_reg)
            S_DECODE:
            begin
                if (item_reg.func == FUNC_ECHO && echo_en_reg && !item_reg.echo_level)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {2'b0, echo_width};
                    div_req.divisor  = (divisor_cfg_reg == '0) ? 16'd1
                                                               : {6'b0, divisor_cfg_reg};
                end
                else if (item_reg.func == FUNC_SPEED)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = 18'(item_reg.speed_sample) * 18'd49;
                    div_req.divisor  = 16'd4095;
                end
            end
            S_MUL:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = prod_reg;
                div_req.divisor  = {4'b0, span[11:0]};
            end
            default: ;
        endcase
    end

    function automatic logic [6:0] turn_duty(input logic [2:0] ph, input logic a);
        logic [6:0] r;
        r = '0;
        if (ph == 3'd2) r = a ? 7'd0 : 7'(DutyMax);
        else r = a ? 7'(DutyMax) : 7'd0;
        return r;
    endfunction

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            divisor_cfg_reg <= 10'd90;
            near_cfg_reg    <= 10'd10;
            far_cfg_reg     <= 10'd20;
            settle_cfg_reg  <= 16'd500;
            quarter_cfg_reg <= 16'd480;
            half_cfg_reg    <= 16'd970;
            floor_cfg_reg   <= 7'd35;
            echo_start_reg  <= '0;
            range_reg       <= '0;
            zone_reg        <= '0;
            turn_phase_reg  <= 3'd1;
            last_turn_reg   <= '0;
            drive_mode_reg  <= 3'd1;
            top_duty_reg    <= 7'd50;
            echo_en_reg     <= 1'b1;
            phase_timer_reg <= '0;
            timer_kind_reg  <= '0;
            duty_a_reg      <= '0;
            duty_b_reg      <= '0;
            dir_a_reg       <= 1'b0;
            dir_b_reg       <= 1'b0;
            buzzer_reg      <= 1'b0;
            err_reg         <= 1'b0;
            brk_sel_reg     <= 1'b0;
            brk_neg_reg     <= 1'b0;
            prod_reg        <= '0;
            brk_a_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DIVISOR: divisor_cfg_reg <= cfg_data[9:0];
                    CFG_NEAR:    near_cfg_reg    <= cfg_data[9:0];
                    CFG_FAR:     far_cfg_reg     <= cfg_data[9:0];
                    CFG_SETTLE:  settle_cfg_reg  <= cfg_data;
                    CFG_QUARTER: quarter_cfg_reg <= cfg_data;
                    CFG_HALF:    half_cfg_reg    <= cfg_data;
                    CFG_FLOOR:   floor_cfg_reg   <= cfg_data[6:0];
                    default: ;
                endcase
            end
            if (state_reg == S_FINISH && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                        state_reg <= S_DECODE;
                end
                S_DECODE:
                begin
                    err_reg   <= item_reg.func == FUNC_CMD && !cmd_ok;
                    state_reg <= decode_next;
                    case (item_reg.func)
                        FUNC_ECHO:
                        begin
                            if (echo_en_reg && item_reg.echo_level)
                                echo_start_reg <= item_reg.capture_time;
                        end
                        FUNC_TICK:
                        begin
                            case (drive_mode_reg)
                                3'd1:
                                begin
                                    {duty_a_reg, duty_b_reg} <= '0;
                                    {dir_a_reg, dir_b_reg} <= 2'b00;
                                end
                                3'd2:
                                begin
                                    duty_a_reg <= peak_a;
                                    duty_b_reg <= top_duty_reg;
                                    {dir_a_reg, dir_b_reg} <= 2'b00;
                                end
                                3'd3:
                                begin
                                    duty_a_reg <= 7'(DutyMax) - peak_a;
                                    duty_b_reg <= 7'(DutyMax) - top_duty_reg;
                                    {dir_a_reg, dir_b_reg} <= 2'b11;
                                end
                                3'd4:
                                begin
                                    duty_a_reg <= '0;
                                    duty_b_reg <= 7'(DutyMax);
                                    {dir_a_reg, dir_b_reg} <= 2'b10;
                                end
                                3'd5:
                                begin
                                    duty_a_reg <= 7'(DutyMax);
                                    duty_b_reg <= '0;
                                    {dir_a_reg, dir_b_reg} <= 2'b01;
                                end
                                3'd6:
                                begin
                                    if (zone_reg == 2'd0)
                                    begin
                                        buzzer_reg <= 1'b1;
                                        {duty_a_reg, duty_b_reg} <= '0;
                                        {dir_a_reg, dir_b_reg} <= 2'b00;
                                        if (turn_phase_reg == 3'd0)
                                        begin
                                            echo_en_reg     <= 1'b0;
                                            timer_kind_reg  <= 2'd1;
                                            phase_timer_reg <= settle_cfg_reg;
                                            turn_phase_reg  <= 3'd1;
                                        end
                                    end
                                    else if (zone_reg == 2'd1)
                                    begin
                                        buzzer_reg <= ~buzzer_reg;
                                        {dir_a_reg, dir_b_reg} <= 2'b00;
                                        if (span <= 0)
                                        begin
                                            duty_a_reg <= floor_clamped;
                                            duty_b_reg <= floor_clamped;
                                        end
                                        else
                                            brk_sel_reg <= 1'b0;
                                    end
                                    else
                                    begin
                                        buzzer_reg <= 1'b0;
                                        duty_a_reg <= peak_a;
                                        duty_b_reg <= top_duty_reg;
                                        {dir_a_reg, dir_b_reg} <= 2'b00;
                                    end
                                end
                                default: ;
                            endcase
                        end
                        FUNC_CMD:
                        begin
                            if (cmd_ok)
                                drive_mode_reg <= 3'(item_reg.command_byte - 8'h30);
                        end
                        FUNC_MS:
                        begin
                            if (timer_kind_reg != 2'd0)
                            begin
                                if (phase_timer_reg > 16'd1)
                                    phase_timer_reg <= phase_timer_reg - 16'd1;
                                else if (timer_kind_reg == 2'd1)
                                begin
                                    if (last_turn_reg == 3'd4)
                                    begin
                                        turn_phase_reg <= 3'd2;
                                        last_turn_reg  <= 3'd2;
                                        timer_kind_reg <= 2'd2;
                                        phase_timer_reg <= quarter_cfg_reg;
                                        duty_a_reg <= 7'd0;
                                        duty_b_reg <= 7'(DutyMax);
                                        {dir_a_reg, dir_b_reg} <= 2'b10;
                                    end
                                    else if (last_turn_reg == 3'd2 ||
                                             last_turn_reg == 3'd3)
                                    begin
                                        turn_phase_reg <= last_turn_reg + 3'd1;
                                        last_turn_reg  <= last_turn_reg + 3'd1;
                                        timer_kind_reg <= 2'd2;
                                        phase_timer_reg <= (last_turn_reg == 3'd2)
                                            ? half_cfg_reg : quarter_cfg_reg;
                                        duty_a_reg <= 7'(DutyMax);
                                        duty_b_reg <= 7'd0;
                                        {dir_a_reg, dir_b_reg} <= 2'b01;
                                    end
                                    else
                                    begin
                                        phase_timer_reg <= '0;
                                        last_turn_reg  <= turn_phase_reg;
                                        timer_kind_reg <= 2'd0;
                                    end
                                end
                                else
                                begin
                                    phase_timer_reg <= '0;
                                    timer_kind_reg <= 2'd0;
                                    echo_en_reg    <= 1'b1;
                                    if (turn_phase_reg != 3'd4)
                                        zone_reg <= 2'd0;
                                    turn_phase_reg <= 3'd1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                S_ECHO_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        range_reg <= dist_cm;
                        // zone: clear above far, caution from near up to far, near below near
                        if (dist_cm > far_cfg_reg)
                            zone_reg <= 2'd2;
                        else if (dist_cm >= near_cfg_reg)
                            zone_reg <= 2'd1;
                        else
                            zone_reg <= 2'd0;
                        if (dist_cm < near_cfg_reg)
                            turn_phase_reg <= 3'd0;
                        if (dist_cm >= near_cfg_reg && dist_cm <= far_cfg_reg)
                            last_turn_reg <= 3'd4;
                        state_reg <= S_FINISH;
                    end
                end
                S_SPEED_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        top_duty_reg <= 7'(div_rsp.quotient) + 7'd50;
                        state_reg    <= S_FINISH;
                    end
                end
                S_BRK_A, S_BRK_B:
                begin
                    prod_reg    <= 18'(prod_s < 0 ? -prod_s : prod_s);
                    brk_neg_reg <= prod_s < 0;
                    state_reg   <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_BRK_WAIT;
                end
                S_BRK_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        if (!brk_sel_reg)
                        begin
                            brk_a_reg   <= brk_clamped;
                            brk_sel_reg <= 1'b1;
                            state_reg   <= S_BRK_B;
                        end
                        else
                        begin
                            duty_a_reg <= brk_a_reg;
                            duty_b_reg <= brk_clamped;
                            state_reg  <= S_FINISH;
                        end
                    end
                end
                S_FINISH:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        state_reg <= S_IDLE;
                        // a running turn overrides the drive on control ticks
                        if (turn_ovr)
                        begin
                            duty_a_reg <= turn_duty(turn_phase_reg, 1'b1);
                            duty_b_reg <= turn_duty(turn_phase_reg, 1'b0);
                            dir_a_reg  <= turn_phase_reg == 3'd2;
                            dir_b_reg  <= turn_phase_reg != 3'd2;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_data;
    end

    // output register, with turn override on control ticks
    always_ff @(posedge clk)
    begin
        if (state_reg == S_FINISH && (!out_valid_reg || out_ready))
        begin
            out_reg.duty_a    <= turn_ovr ? turn_duty(turn_phase_reg, 1'b1) : duty_a_reg;
            out_reg.duty_b    <= turn_ovr ? turn_duty(turn_phase_reg, 1'b0) : duty_b_reg;
            out_reg.dir_a     <= turn_ovr ? (turn_phase_reg == 3'd2) : dir_a_reg;
            out_reg.dir_b     <= turn_ovr ? (turn_phase_reg != 3'd2) : dir_b_reg;
            out_reg.buzzer_on <= buzzer_reg;
            out_reg.range_cm  <= range_reg;
            out_reg.zone      <= zone_reg;
            out_reg.cmd_error <= err_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `CHK_IMPLY(a_ready_idle, clk, rst_n, in_ready, state_reg == S_IDLE, "ready outside idle")
    `CHK_NEXT(a_accept_decode, clk, rst_n, in_valid && in_ready, state_reg == S_DECODE, "accepted transfer not decoded")
    `CHK_IMPLY(a_top_range, clk, rst_n, 1'b1, top_duty_reg >= 7'd50 && top_duty_reg <= 7'd99, "top duty out of range")
endmodule

/* bench/ultrasonic_obstacle_drive_controller_core_test.sv */
// Self-checking testbench for the ultrasonic obstacle drive controller core
`timescale 1ns / 1ps

module ultrasonic_obstacle_drive_controller_core_test;
    import uodc_pkg::*;

    localparam int WatchdogLimit = 5000;
    localparam int HoldOffCycles = 400;

    localparam logic [1:0] ZONE_NEAR = 2'd0;
    localparam logic [1:0] ZONE_CAUTION = 2'd1;
    localparam logic [1:0] ZONE_CLEAR = 2'd2;

    localparam logic [2:0] TURN_ARMED = 3'd0;
    localparam logic [2:0] TURN_IDLE = 3'd1;
    localparam logic [2:0] TURN_RIGHT90 = 3'd2;
    localparam logic [2:0] TURN_LEFT180 = 3'd3;
    localparam logic [2:0] TURN_LEFT90 = 3'd4;

    localparam logic [2:0] MODE_STOP = 3'd1;
    localparam logic [2:0] MODE_FWD = 3'd2;
    localparam logic [2:0] MODE_BACK = 3'd3;
    localparam logic [2:0] MODE_RIGHT = 3'd4;
    localparam logic [2:0] MODE_LEFT = 3'd5;
    localparam logic [2:0] MODE_AUTO = 3'd6;

    localparam logic [1:0] TIMER_NONE = 2'd0;
    localparam logic [1:0] TIMER_SETTLE = 2'd1;
    localparam logic [1:0] TIMER_TURN = 2'd2;

    localparam logic [2:0] FUNC_UNUSED5 = 3'd5;
    localparam logic [2:0] FUNC_UNUSED7 = 3'd7;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_data;
    logic out_valid;
    logic out_ready;
    out_item_t out_data;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [15:0] cfg_data;

    ultrasonic_obstacle_drive_controller_core uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // predictor copy of the registers and state
    logic [9:0] div_r, near_r, far_r;
    logic [15:0] settle_r, quarter_r, half_r;
    logic [6:0] floor_r;
    logic [15:0] echo_start_q, phase_timer_q;
    logic [9:0] range_q;
    logic [1:0] zone_q, timer_kind_q;
    logic [2:0] turn_phase_q, last_turn_q, mode_q;
    logic [6:0] top_q, duty_a_q, duty_b_q;
    logic dir_a_q, dir_b_q, buzzer_q, echo_en_q;

    out_item_t drive_results_q[$];
    int idle_pct;
    int stall_pct;
    bit hold_off;
    int mismatches;
    int idle_cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [6:0] clamp_duty(input int v);
        if (v < 0)
            return 7'd0;
        if (v > DutyMax)
            return 7'(DutyMax);
        return 7'(v);
    endfunction

    function automatic logic [6:0] peak_a();
        return top_q - top_q / 7'd10;
    endfunction

    function automatic logic [6:0] brake_duty(input logic [6:0] peak);
        int span;
        int v;
        span = int'(far_r) - int'(near_r);
        if (span <= 0)
            return clamp_duty(int'(floor_r));
        v = (int'(peak) - int'(floor_r)) * (int'(range_q) - int'(near_r));
        return clamp_duty(v / span + int'(floor_r));
    endfunction

    task automatic set_drive(input logic [6:0] da, input logic [6:0] db,
                             input logic ra, input logic rb);
        duty_a_q = da;
        duty_b_q = db;
        dir_a_q = ra;
        dir_b_q = rb;
    endtask

    task automatic apply_turn();
        if (turn_phase_q == TURN_RIGHT90)
            set_drive(7'd0, 7'(DutyMax), 1'b1, 1'b0);
        else if (turn_phase_q == TURN_LEFT180 || turn_phase_q == TURN_LEFT90)
            set_drive(7'(DutyMax), 7'd0, 1'b0, 1'b1);
    endtask

    task automatic reset_model();
        div_r = 10'd90;
        near_r = 10'd10;
        far_r = 10'd20;
        settle_r = 16'd500;
        quarter_r = 16'd480;
        half_r = 16'd970;
        floor_r = 7'd35;
        echo_start_q = '0;
        range_q = '0;
        zone_q = ZONE_NEAR;
        turn_phase_q = TURN_IDLE;
        last_turn_q = '0;
        mode_q = MODE_STOP;
        top_q = 7'd50;
        echo_en_q = 1'b1;
        phase_timer_q = '0;
        timer_kind_q = TIMER_NONE;
        set_drive(7'd0, 7'd0, 1'b0, 1'b0);
        buzzer_q = 1'b0;
    endtask

    task automatic predict_drive(input in_item_t it, output out_item_t r);
        logic [15:0] pulse;
        logic [15:0] d;
        logic err;
        err = 1'b0;
        case (it.func)
            FUNC_ECHO:
                if (echo_en_q)
                begin
                    if (it.echo_level)
                        echo_start_q = it.capture_time;
                    else
                    begin
                        pulse = it.capture_time - echo_start_q;
                        d = pulse / ((div_r == 0) ? 16'd1 : 16'(div_r));
                        if (d > 16'd1023)
                            d = 16'd1023;
                        range_q = d[9:0];
                        if (range_q < near_r)
                        begin
                            zone_q = ZONE_NEAR;
                            turn_phase_q = TURN_ARMED;
                        end
                        if (range_q >= near_r && range_q <= far_r)
                        begin
                            zone_q = ZONE_CAUTION;
                            last_turn_q = TURN_LEFT90;
                        end
                        if (range_q > far_r)
                            zone_q = ZONE_CLEAR;
                    end
                end
            FUNC_TICK:
            begin
                case (mode_q)
                    MODE_STOP: set_drive(7'd0, 7'd0, 1'b0, 1'b0);
                    MODE_FWD: set_drive(peak_a(), top_q, 1'b0, 1'b0);
                    MODE_BACK: set_drive(7'(DutyMax) - peak_a(), 7'(DutyMax) - top_q,
                                         1'b1, 1'b1);
                    MODE_RIGHT: set_drive(7'd0, 7'(DutyMax), 1'b1, 1'b0);
                    MODE_LEFT: set_drive(7'(DutyMax), 7'd0, 1'b0, 1'b1);
                    MODE_AUTO:
                        if (zone_q == ZONE_NEAR)
                        begin
                            buzzer_q = 1'b1;
                            set_drive(7'd0, 7'd0, 1'b0, 1'b0);
                            if (turn_phase_q == TURN_ARMED)
                            begin
                                echo_en_q = 1'b0;
                                timer_kind_q = TIMER_SETTLE;
                                phase_timer_q = settle_r;
                                turn_phase_q = TURN_IDLE;
                            end
                        end
                        else if (zone_q == ZONE_CAUTION)
                        begin
                            set_drive(brake_duty(peak_a()), brake_duty(top_q), 1'b0, 1'b0);
                            buzzer_q = ~buzzer_q;
                        end
                        else
                        begin
                            buzzer_q = 1'b0;
                            set_drive(peak_a(), top_q, 1'b0, 1'b0);
                        end
                    default: ;
                endcase
                if (timer_kind_q == TIMER_TURN)
                    apply_turn();
            end
            FUNC_CMD:
                if (it.command_byte >= "1" && it.command_byte <= "6")
                    mode_q = 3'(it.command_byte - "0");
                else
                    err = 1'b1;
            FUNC_SPEED:
                top_q = 7'(int'(it.speed_sample) * 49 / 4095 + 50);
            FUNC_MS:
                if (timer_kind_q != TIMER_NONE)
                begin
                    if (phase_timer_q > 16'd1)
                        phase_timer_q = phase_timer_q - 16'd1;
                    else
                    begin
                        phase_timer_q = '0;
                        if (timer_kind_q == TIMER_SETTLE)
                        begin
                            if (last_turn_q == TURN_LEFT90)
                                turn_phase_q = TURN_RIGHT90;
                            else if (last_turn_q == TURN_RIGHT90)
                                turn_phase_q = TURN_LEFT180;
                            else if (last_turn_q == TURN_LEFT180)
                                turn_phase_q = TURN_LEFT90;
                            last_turn_q = turn_phase_q;
                            if (turn_phase_q >= TURN_RIGHT90 && turn_phase_q <= TURN_LEFT90)
                            begin
                                timer_kind_q = TIMER_TURN;
                                phase_timer_q = (turn_phase_q == TURN_LEFT180) ?
                                                half_r : quarter_r;
                                apply_turn();
                            end
                            else
                                timer_kind_q = TIMER_NONE;
                        end
                        else
                        begin
                            timer_kind_q = TIMER_NONE;
                            echo_en_q = 1'b1;
                            if (turn_phase_q != TURN_LEFT90)
                                zone_q = ZONE_NEAR;
                            turn_phase_q = TURN_IDLE;
                        end
                    end
                end
            default: ;
        endcase
        r.duty_a = duty_a_q;
        r.duty_b = duty_b_q;
        r.dir_a = dir_a_q;
        r.dir_b = dir_b_q;
        r.buzzer_on = buzzer_q;
        r.range_cm = range_q;
        r.zone = zone_q;
        r.cmd_error = err;
    endtask

    task automatic send_event(input in_item_t it);
        out_item_t r;
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_drive(it, r);
        drive_results_q.push_back(r);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (drive_results_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input int val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 16'(val);
        case (idx)
            CFG_DIVISOR: div_r = 10'(val);
            CFG_NEAR: near_r = 10'(val);
            CFG_FAR: far_r = 10'(val);
            CFG_SETTLE: settle_r = 16'(val);
            CFG_QUARTER: quarter_r = 16'(val);
            CFG_HALF: half_r = 16'(val);
            CFG_FLOOR: floor_r = 7'(val);
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(input int dv, input int nr, input int fr, input int st,
                             input int qt, input int hf, input int fl);
        write_reg(CFG_DIVISOR, dv);
        write_reg(CFG_NEAR, nr);
        write_reg(CFG_FAR, fr);
        write_reg(CFG_SETTLE, st);
        write_reg(CFG_QUARTER, qt);
        write_reg(CFG_HALF, hf);
        write_reg(CFG_FLOOR, fl);
    endtask

    function automatic in_item_t noise_item();
        return in_item_t'(40'({$urandom, $urandom}));
    endfunction

    task automatic send_op(input logic [2:0] f, input logic lvl, input int cap,
                           input int cmd, input int spd);
        in_item_t it;
        it = noise_item();
        it.func = f;
        it.echo_level = lvl;
        it.capture_time = 16'(cap);
        it.command_byte = 8'(cmd);
        it.speed_sample = 12'(spd);
        send_event(it);
    endtask

    task automatic send_tick();
        in_item_t it;
        it = noise_item();
        it.func = FUNC_TICK;
        send_event(it);
    endtask

    task automatic send_ms();
        in_item_t it;
        it = noise_item();
        it.func = FUNC_MS;
        send_event(it);
    endtask

    task automatic send_cmd(input int cmd);
        in_item_t it;
        it = noise_item();
        it.func = FUNC_CMD;
        it.command_byte = 8'(cmd);
        send_event(it);
    endtask

    // rising then falling edge with a pulse for the requested distance
    task automatic send_pulse(input int dist_cm);
        in_item_t it;
        int dv;
        int w;
        int rise;
        dv = (div_r == 0) ? 1 : int'(div_r);
        w = dist_cm * dv + $urandom_range(0, dv - 1);
        if (w > 65535)
            w = 65535;
        rise = $urandom_range(0, 65535);
        it = noise_item();
        it.func = FUNC_ECHO;
        it.echo_level = 1'b1;
        it.capture_time = 16'(rise);
        send_event(it);
        it = noise_item();
        it.func = FUNC_ECHO;
        it.echo_level = 1'b0;
        it.capture_time = 16'(rise + w);
        send_event(it);
    endtask

    task automatic random_burst(input int count);
        int sent;
        int pick;
        int dist_cm;
        in_item_t it;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                case ($urandom_range(0, 3))
                    0: dist_cm = $urandom_range(0, 1023);
                    1: dist_cm = 5000;
                    default: dist_cm = int'(near_r) + $urandom_range(0, 6) - 3 +
                                       (($urandom_range(0, 1) != 0) ?
                                        int'(far_r) - int'(near_r) : 0);
                endcase
                if (dist_cm < 0)
                    dist_cm = 0;
                send_pulse(dist_cm);
                sent += 2;
            end
            else
            begin
                if (pick < 55)
                    send_tick();
                else if (pick < 65)
                    send_cmd(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) :
                             (($urandom_range(0, 1) != 0) ? "6" : $urandom_range("1", "6")));
                else if (pick < 72)
                    send_op(FUNC_SPEED, 1'b0, 0, 0, $urandom_range(0, 4095));
                else if (pick < 95)
                    send_ms();
                else
                begin
                    it = noise_item();
                    send_event(it);
                end
                sent++;
            end
        end
    endtask

    task automatic test_directed();
        idle_pct = 0;
        stall_pct = 0;
        send_cmd("0");
        send_cmd("7");
        send_cmd(8'h00);
        send_cmd(8'hFF);
        send_op(FUNC_SPEED, 1'b0, 0, 0, 4095);
        for (int c = "1"; c <= "5"; c++)
        begin
            send_cmd(c);
            send_tick();
        end
        send_op(FUNC_SPEED, 1'b0, 0, 0, 0);
        send_cmd("3");
        send_tick();
        send_op(FUNC_ECHO, 1'b1, 16'hFFF0, 0, 0);
        send_op(FUNC_ECHO, 1'b0, 16'h0010, 0, 0);
        send_op(FUNC_UNUSED5, 1'b1, 16'hFFFF, 8'hFF, 12'hFFF);
        send_op(FUNC_UNUSED7, 1'b0, 0, 0, 0);
        send_cmd("6");
        send_tick();
        send_ms();
        drain();
    endtask

    task automatic test_idle_phases();
        int ip[4];
        int sp[4];
        int nr;
        ip = '{0, 76, 0, 19};
        sp = '{0, 0, 76, 19};
        for (int p = 0; p < 4; p++)
        begin
            idle_pct = ip[p];
            stall_pct = sp[p];
            nr = $urandom_range(3, 30);
            write_all($urandom_range(1, 120), nr, nr + $urandom_range(0, 30),
                      $urandom_range(0, 4), $urandom_range(0, 3), $urandom_range(0, 6),
                      $urandom_range(0, 99));
            send_cmd("6");
            random_burst(340);
            drain();
        end
    endtask

    task automatic test_register_extremes();
        idle_pct = 19;
        stall_pct = 19;
        write_all(1023, 0, 1023, 65535, 65535, 65535, 99);
        random_burst(60);
        drain();
        write_all(0, 1023, 0, 0, 0, 0, 0);
        send_op(FUNC_ECHO, 1'b1, 0, 0, 0);
        send_op(FUNC_ECHO, 1'b0, 16'hFFFF, 0, 0);
        random_burst(60);
        drain();
        write_all(1, 500, 100, 1, 2, 3, 50);
        random_burst(60);
        drain();
    endtask

    task automatic test_pressure();
        idle_pct = 0;
        stall_pct = 0;
        write_all(30, 10, 40, 2, 2, 3, 20);
        fork
            begin
                hold_off = 1'b1;
                repeat (HoldOffCycles) @(posedge clk);
                hold_off = 1'b0;
            end
            random_burst(40);
        join
        drain();
    endtask

    always @(negedge clk)
        out_ready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (drive_results_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", out_data);
            end
            else if (out_data.duty_a !== drive_results_q[0].duty_a ||
                     out_data.duty_b !== drive_results_q[0].duty_b ||
                     out_data.dir_a !== drive_results_q[0].dir_a ||
                     out_data.dir_b !== drive_results_q[0].dir_b ||
                     out_data.buzzer_on !== drive_results_q[0].buzzer_on ||
                     out_data.range_cm !== drive_results_q[0].range_cm ||
                     out_data.zone !== drive_results_q[0].zone ||
                     out_data.cmd_error !== drive_results_q[0].cmd_error)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p got %p", drive_results_q[0], out_data);
            end
            if (drive_results_q.size() != 0)
                void'(drive_results_q.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == WatchdogLimit)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_off = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        mismatches = 0;
        idle_cycles = 0;
        reset_model();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_idle_phases();
        test_register_extremes();
        test_pressure();
        repeat (50) @(posedge clk);
        if (mismatches == 0 && drive_results_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
